[rtl/mwm_pkg.sv]
package mwm_pkg;

  // Command and fixed-point formats
  localparam int IN_W      = 16;
  localparam int FRAC_BITS = 14;
  localparam int DAC_BITS  = 12;
  localparam int WHEELS    = 4;

  // Wheel order on internal vectors
  localparam int FL = 0;
  localparam int FR = 1;
  localparam int RL = 2;
  localparam int RR = 3;

  // Three commands summed need two extra bits; the magnitude drops the sign bit
  localparam int SUM_W  = IN_W + 2;
  localparam int MAG_W  = IN_W + 1;
  // The divisor must hold both the largest magnitude and 1.0
  localparam int DIV_W  = (MAG_W > FRAC_BITS + 1) ? MAG_W : FRAC_BITS + 1;
  localparam int REM_W  = DIV_W + 1;
  // Normalized power never exceeds 1.0
  localparam int Q_W    = FRAC_BITS + 1;
  localparam int PROD_W = Q_W + DAC_BITS;

  localparam logic [DIV_W-1:0]    ONE     = DIV_W'(1) << FRAC_BITS;
  localparam logic [DAC_BITS-1:0] DAC_MAX = '1;

  // Mixer to divider: magnitudes, signs and the shared divisor
  typedef struct packed {
    logic [DIV_W-1:0]                divisor;
    logic [WHEELS-1:0]               rev;
    logic [WHEELS-1:0][MAG_W-1:0]    mag;
  } mix_out_t;

  // One stage of the divider pipeline
  typedef struct packed {
    logic [DIV_W-1:0]                divisor;
    logic [WHEELS-1:0]               rev;
    logic [WHEELS-1:0][REM_W-1:0]    rem;
    logic [WHEELS-1:0][Q_W-1:0]      quo;
  } div_stage_t;

  // Divider to scaler: normalized magnitudes and signs
  typedef struct packed {
    logic [WHEELS-1:0]               rev;
    logic [WHEELS-1:0][Q_W-1:0]      quo;
  } div_out_t;

endpackage

[rtl/mwm_mix.sv]
module mwm_mix
  import mwm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [IN_W-1:0] strafe,
  input  logic signed [IN_W-1:0] forward,
  input  logic signed [IN_W-1:0] rotate,
  output logic                  out_valid,
  input  logic                  out_ready,
  output mix_out_t              out
);

  logic [2:0] v;
  logic [2:0] load;

  logic signed [SUM_W-1:0] x;
  logic signed [SUM_W-1:0] y;
  logic signed [SUM_W-1:0] t;
  logic signed [SUM_W-1:0] sum [WHEELS];

  logic [WHEELS-1:0][MAG_W-1:0] mag;
  logic [WHEELS-1:0]            rev;

  logic [MAG_W-1:0] max_a;
  logic [MAG_W-1:0] max_b;
  logic [MAG_W-1:0] max_all;

  mix_out_t res;

  // Each stage loads when empty or when the next one takes its request
  assign load     = ~v | {out_ready, load[2:1]};
  assign in_ready = load[0];
  assign out_valid = v[2];
  assign out       = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (load[0]) v[0] <= in_valid;
      if (load[1]) v[1] <= v[0];
      if (load[2]) v[2] <= v[1];
    end
  end

  // Stage 1: mix the three commands into four wheel powers
  assign x = SUM_W'(strafe);
  assign y = SUM_W'(forward);
  assign t = SUM_W'(rotate);

  always_ff @(posedge clk) begin
    if (load[0]) begin
      sum[FL] <= y + x + t;
      sum[FR] <= y - x - t;
      sum[RL] <= y - x + t;
      sum[RR] <= y + x - t;
    end
  end

  // Stage 2: split each power into sign and magnitude
  always_ff @(posedge clk) begin
    if (load[1]) begin
      for (int w = 0; w < WHEELS; w++) begin
        rev[w] <= sum[w][SUM_W-1];
        mag[w] <= sum[w][SUM_W-1] ? MAG_W'(-sum[w]) : MAG_W'(sum[w]);
      end
    end
  end

  // Stage 3: find the largest magnitude; divide by 1.0 unless it exceeds 1.0
  assign max_a   = (mag[FL] > mag[FR]) ? mag[FL] : mag[FR];
  assign max_b   = (mag[RL] > mag[RR]) ? mag[RL] : mag[RR];
  assign max_all = (max_a > max_b) ? max_a : max_b;

  always_ff @(posedge clk) begin
    if (load[2]) begin
      res.rev     <= rev;
      res.mag     <= mag;
      res.divisor <= (DIV_W'(max_all) > ONE) ? DIV_W'(max_all) : ONE;
    end
  end

  // The divisor never drops below 1.0 and bounds every magnitude
  for (genvar w = 0; w < WHEELS; w++) begin : g_chk
    a_mag_bounded: assert property (@(posedge clk) disable iff (rst)
      v[2] |-> DIV_W'(res.mag[w]) <= res.divisor)
      else $error("wheel magnitude above divisor");
  end

  a_div_floor: assert property (@(posedge clk) disable iff (rst)
    v[2] |-> res.divisor >= ONE)
    else $error("divisor below one");

endmodule

[rtl/mwm_div.sv]
module mwm_div
  import mwm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  mix_out_t in,
  output logic     out_valid,
  input  logic     out_ready,
  output div_out_t out
);

  logic [Q_W-1:0] v;
  logic [Q_W-1:0] load;
  div_stage_t     st [Q_W];
  div_stage_t     head;

  // Advance each stage when empty or when the next one takes its request
  assign load      = ~v | {out_ready, load[Q_W-1:1]};
  assign in_ready  = load[0];
  assign out_valid = v[Q_W-1];
  assign out.rev   = st[Q_W-1].rev;
  assign out.quo   = st[Q_W-1].quo;

  // Enter with remainder = magnitude and an empty quotient
  always_comb begin
    head.divisor = in.divisor;
    head.rev     = in.rev;
    head.quo     = '0;
    for (int w = 0; w < WHEELS; w++) begin
      head.rem[w] = REM_W'(in.mag[w]);
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    div_stage_t src;
    logic       src_v;
    div_stage_t nxt;

    if (k == 0) begin : g_first
      assign src   = head;
      assign src_v = in_valid;
    end else begin : g_rest
      assign src   = st[k-1];
      assign src_v = v[k-1];
    end

    // Trial subtract against the divisor; the first stage skips the shift
    always_comb begin
      logic [REM_W-1:0] trial;
      logic             ge;
      nxt = src;
      for (int w = 0; w < WHEELS; w++) begin
        trial = (k == 0) ? src.rem[w] : {src.rem[w][REM_W-2:0], 1'b0};
        ge    = trial >= REM_W'(src.divisor);
        nxt.rem[w] = ge ? trial - REM_W'(src.divisor) : trial;
        nxt.quo[w][FRAC_BITS-k] = ge;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (load[k]) begin
        v[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (load[k]) begin
        st[k] <= nxt;
      end
    end
  end

  // Normalized power stays within 1.0 and the remainder below the divisor
  for (genvar w = 0; w < WHEELS; w++) begin : g_chk
    a_quo_bounded: assert property (@(posedge clk) disable iff (rst)
      v[Q_W-1] |-> REM_W'(st[Q_W-1].quo[w]) <= REM_W'(ONE))
      else $error("normalized power above one");
    a_rem_bounded: assert property (@(posedge clk) disable iff (rst)
      v[Q_W-1] |-> st[Q_W-1].rem[w] < REM_W'(st[Q_W-1].divisor))
      else $error("divider remainder not reduced");
  end

endmodule

[rtl/mwm_scale.sv]
module mwm_scale
  import mwm_pkg::*;
(
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  div_out_t                        in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [WHEELS-1:0][DAC_BITS-1:0] level,
  output logic [WHEELS-1:0]               reverse
);

  logic [1:0] v;
  logic [1:0] load;

  logic [WHEELS-1:0][PROD_W-1:0] prod;
  logic [WHEELS-1:0]             prod_rev;

  // Advance each stage when empty or when the next one takes its request
  assign load      = ~v | {out_ready, load[1]};
  assign in_ready  = load[0];
  assign out_valid = v[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (load[0]) v[0] <= in_valid;
      if (load[1]) v[1] <= v[0];
    end
  end

  // Stage 1: scale the normalized power to the DAC range
  always_ff @(posedge clk) begin
    if (load[0]) begin
      prod_rev <= in.rev;
      for (int w = 0; w < WHEELS; w++) begin
        prod[w] <= PROD_W'(in.quo[w]) * PROD_W'(DAC_MAX);
      end
    end
  end

  // Stage 2: drop the fraction, clamp to full scale and hold the result
  always_ff @(posedge clk) begin
    if (load[1]) begin
      reverse <= prod_rev;
      for (int w = 0; w < WHEELS; w++) begin
        if (prod[w][PROD_W-1:FRAC_BITS] > (DAC_BITS+1)'(DAC_MAX)) begin
          level[w] <= DAC_MAX;
        end else begin
          level[w] <= prod[w][FRAC_BITS+DAC_BITS-1:FRAC_BITS];
        end
      end
    end
  end

  // A power within 1.0 never reaches the clamp
  for (genvar w = 0; w < WHEELS; w++) begin : g_chk
    a_no_clamp: assert property (@(posedge clk) disable iff (rst)
      v[0] |-> prod[w][PROD_W-1:FRAC_BITS] <= (DAC_BITS+1)'(DAC_MAX))
      else $error("DAC level above full scale");
  end

endmodule

[rtl/mecanum_wheel_mixer.sv]
// Mecanum wheel mixer: takes strafe, forward and rotate commands in signed Q2.14
// (16384 = 1.0), mixes them into four wheel powers, scales all four down by the
// largest magnitude when it exceeds 1.0, and reports each wheel as a reverse bit
// plus a 12-bit DAC level. The pipeline accepts one request per clock while the
// output is not stalled; each request passes through three mixing stages, one
// divider stage per quotient bit (FRAC_BITS + 1), and two scaling stages. A
// stalled output backs up stage by stage, so empty stages keep taking requests.
// enable_out follows the motors_enabled bit written on the configuration port,
// which resets to 0.
module mecanum_wheel_mixer
  import mwm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [IN_W-1:0] strafe,
  input  logic signed [IN_W-1:0] forward,
  input  logic signed [IN_W-1:0] rotate,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DAC_BITS-1:0]  front_left_level,
  output logic                 front_left_reverse,
  output logic [DAC_BITS-1:0]  front_right_level,
  output logic                 front_right_reverse,
  output logic [DAC_BITS-1:0]  rear_left_level,
  output logic                 rear_left_reverse,
  output logic [DAC_BITS-1:0]  rear_right_level,
  output logic                 rear_right_reverse,
  output logic                 enable_out
);

  logic     motors_enabled;

  logic     mix_valid;
  logic     mix_ready;
  mix_out_t mix_data;

  logic     div_valid;
  logic     div_ready;
  div_out_t div_data;

  logic [WHEELS-1:0][DAC_BITS-1:0] level;
  logic [WHEELS-1:0]               reverse;

  // Hold the motor enable level
  always_ff @(posedge clk) begin
    if (rst) begin
      motors_enabled <= 1'b0;
    end else if (cfg_wr_en) begin
      motors_enabled <= cfg_wr_data;
    end
  end

  assign enable_out = motors_enabled;

  mwm_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .strafe    (strafe),
    .forward   (forward),
    .rotate    (rotate),
    .out_valid (mix_valid),
    .out_ready (mix_ready),
    .out       (mix_data)
  );

  mwm_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mix_valid),
    .in_ready  (mix_ready),
    .in        (mix_data),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out       (div_data)
  );

  mwm_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (div_valid),
    .in_ready  (div_ready),
    .in        (div_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .level     (level),
    .reverse   (reverse)
  );

  assign front_left_level    = level[FL];
  assign front_left_reverse  = reverse[FL];
  assign front_right_level   = level[FR];
  assign front_right_reverse = reverse[FR];
  assign rear_left_level     = level[RL];
  assign rear_left_reverse   = reverse[RL];
  assign rear_right_level    = level[RR];
  assign rear_right_reverse  = reverse[RR];

endmodule
